@@ sv/dlm_pkg.sv @@
`timescale 1ns / 1ps

package dlm_pkg;

  // Field widths
  localparam int REP_WIDTH           = 48;
  localparam int INTERVAL_WIDTH      = 22;
  localparam int COUNT_WIDTH_DEFAULT = 48;

  localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 22'd1000;

  // Result kinds
  localparam logic [1:0] KIND_IGNORED = 2'd0;
  localparam logic [1:0] KIND_COUNTED = 2'd1;
  localparam logic [1:0] KIND_INTERIM = 2'd2;
  localparam logic [1:0] KIND_FINAL   = 2'd3;

  // One received datagram descriptor
  typedef struct packed {
    logic signed [31:0] seq_id;
    logic [15:0]        byte_count;
    logic [31:0]        now_ms;
  } dlm_in_t;

  // One result word
  typedef struct packed {
    logic [1:0]           result_kind;
    logic [7:0]           session_number;
    logic [REP_WIDTH-1:0] rep_bytes;
    logic [REP_WIDTH-1:0] rep_datagrams;
    logic [REP_WIDTH-1:0] rep_dropped;
    logic [31:0]          rep_out_of_order;
    logic [31:0]          rep_duration_ms;
  } dlm_out_t;

endpackage

@@ sv/dlm_tracker.sv @@
`timescale 1ns / 1ps

module dlm_tracker #(
  parameter int COUNT_WIDTH = dlm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  dlm_pkg::dlm_in_t                     item,
  input  logic [dlm_pkg::INTERVAL_WIDTH-1:0]   interval,
  output dlm_pkg::dlm_out_t                    result
);
  import dlm_pkg::*;

  // Byte, datagram and drop counters saturate at 2^COUNT_WIDTH-1, clipped to the report width
  localparam int SW = (COUNT_WIDTH < REP_WIDTH) ? COUNT_WIDTH : REP_WIDTH;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [32:0] b);
    logic [SW+32:0] s;
    s = {33'b0, a} + {{SW{1'b0}}, b};
    if (|s[SW+32:SW]) begin
      return '1;
    end
    return s[SW-1:0];
  endfunction

  // Session state
  logic          awaiting_first;
  logic [7:0]    session_count;
  logic [31:0]   session_start;
  logic [31:0]   next_expected;
  logic [SW-1:0] sum_bytes;
  logic [SW-1:0] sum_datagrams;
  logic [SW-1:0] sum_dropped;
  logic [31:0]   sum_out_of_order;
  logic          window_open;
  logic [31:0]   window_start;
  logic [SW-1:0] window_bytes;
  logic [SW-1:0] window_datagrams;
  logic [SW-1:0] window_dropped;

  logic          awaiting_first_next;
  logic [7:0]    session_count_next;
  logic [31:0]   session_start_next;
  logic [31:0]   next_expected_next;
  logic [SW-1:0] sum_bytes_next;
  logic [SW-1:0] sum_datagrams_next;
  logic [SW-1:0] sum_dropped_next;
  logic [31:0]   sum_out_of_order_next;
  logic          window_open_next;
  logic [31:0]   window_start_next;
  logic [SW-1:0] window_bytes_next;
  logic [SW-1:0] window_datagrams_next;
  logic [SW-1:0] window_dropped_next;

  logic [31:0] id;
  logic [31:0] now;
  logic [32:0] bytes;
  logic [32:0] gap;
  logic [31:0] elapsed;
  logic        opening;

  assign id    = item.seq_id;
  assign now   = item.now_ms;
  assign bytes = {17'b0, item.byte_count};

  always_comb begin
    opening = awaiting_first && (id == 32'd0);

    // Id 0 while idle opens a session: start from cleared counters
    awaiting_first_next   = awaiting_first;
    session_count_next    = opening ? session_count + 8'd1 : session_count;
    session_start_next    = opening ? now : session_start;
    next_expected_next    = opening ? '0 : next_expected;
    sum_bytes_next        = opening ? '0 : sum_bytes;
    sum_datagrams_next    = opening ? '0 : sum_datagrams;
    sum_dropped_next      = opening ? '0 : sum_dropped;
    sum_out_of_order_next = opening ? '0 : sum_out_of_order;
    window_open_next      = opening ? 1'b0 : window_open;
    window_start_next     = opening ? '0 : window_start;
    window_bytes_next     = opening ? '0 : window_bytes;
    window_datagrams_next = opening ? '0 : window_datagrams;
    window_dropped_next   = opening ? '0 : window_dropped;

    gap     = {1'b0, id - next_expected_next};
    elapsed = now - window_start_next;

    result                = '0;
    result.session_number = session_count_next;

    if (awaiting_first && !opening) begin
      // idle: drop the word
      result.result_kind = KIND_IGNORED;
    end else if (id[31]) begin
      // end of session
      result.result_kind      = KIND_FINAL;
      result.rep_bytes        = REP_WIDTH'(sum_bytes_next);
      result.rep_datagrams    = REP_WIDTH'(sum_datagrams_next);
      result.rep_dropped      = REP_WIDTH'(sum_dropped_next);
      result.rep_out_of_order = sum_out_of_order_next;
      result.rep_duration_ms  = now - session_start_next;
      awaiting_first_next     = 1'b1;
    end else begin
      awaiting_first_next = 1'b0;
      // sequence tracking
      if (id == next_expected_next) begin
        next_expected_next = next_expected_next + 32'd1;
      end else if (id > next_expected_next) begin
        sum_dropped_next    = sat_add(sum_dropped_next, gap);
        window_dropped_next = sat_add(window_dropped_next, gap);
        next_expected_next  = id + 32'd1;
      end else if (sum_out_of_order_next != '1) begin
        sum_out_of_order_next = sum_out_of_order_next + 32'd1;
      end

      sum_datagrams_next = sat_add(sum_datagrams_next, 33'd1);
      sum_bytes_next     = sat_add(sum_bytes_next, bytes);
      result.result_kind = KIND_COUNTED;

      // interim window
      if (interval != '0) begin
        window_datagrams_next = sat_add(window_datagrams_next, 33'd1);
        window_bytes_next     = sat_add(window_bytes_next, bytes);
        if (window_open_next) begin
          if (elapsed >= {10'b0, interval}) begin
            result.result_kind     = KIND_INTERIM;
            result.rep_bytes       = REP_WIDTH'(window_bytes_next);
            result.rep_datagrams   = REP_WIDTH'(window_datagrams_next);
            result.rep_dropped     = REP_WIDTH'(window_dropped_next);
            result.rep_duration_ms = elapsed;
            window_open_next       = 1'b0;
            window_start_next      = '0;
            window_bytes_next      = '0;
            window_datagrams_next  = '0;
            window_dropped_next    = '0;
          end
        end else begin
          window_open_next  = 1'b1;
          window_start_next = now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first   <= 1'b1;
      session_count    <= '0;
      session_start    <= '0;
      next_expected    <= '0;
      sum_bytes        <= '0;
      sum_datagrams    <= '0;
      sum_dropped      <= '0;
      sum_out_of_order <= '0;
      window_open      <= 1'b0;
      window_start     <= '0;
      window_bytes     <= '0;
      window_datagrams <= '0;
      window_dropped   <= '0;
    end else if (take) begin
      awaiting_first   <= awaiting_first_next;
      session_count    <= session_count_next;
      session_start    <= session_start_next;
      next_expected    <= next_expected_next;
      sum_bytes        <= sum_bytes_next;
      sum_datagrams    <= sum_datagrams_next;
      sum_dropped      <= sum_dropped_next;
      sum_out_of_order <= sum_out_of_order_next;
      window_open      <= window_open_next;
      window_start     <= window_start_next;
      window_bytes     <= window_bytes_next;
      window_datagrams <= window_datagrams_next;
      window_dropped   <= window_dropped_next;
    end
  end

endmodule

@@ sv/datagram_loss_monitor.sv @@
`timescale 1ns / 1ps
// A result word is registered: it is valid in the cycle after its datagram word is accepted.
// Throughput: one word per cycle; in_ready holds high while the result register
// is empty or being drained, so input and output overlap fully.
// Session state is updated in a single pass of adds and compares per word.
// Reset (rst, synchronous): idle awaiting id 0, counters cleared, interval 1000 ms.

module datagram_loss_monitor #(
  parameter int COUNT_WIDTH = dlm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  dlm_pkg::dlm_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dlm_pkg::dlm_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dlm_pkg::INTERVAL_WIDTH-1:0] cfg_data
);
  import dlm_pkg::*;

  logic [INTERVAL_WIDTH-1:0] report_interval_ms;
  dlm_out_t                  result;
  logic                      take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  // interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval_ms <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      report_interval_ms <= cfg_data;
    end
  end

  dlm_tracker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (in_data),
    .interval (report_interval_ms),
    .result   (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

endmodule

@@ sv/dlm_checker.sv @@
`timescale 1ns / 1ps

module dlm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dlm_pkg::dlm_out_t out_data
);
  import dlm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // every accepted word yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // non-report kinds carry zero report fields
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_IGNORED ||
                  out_data.result_kind == KIND_COUNTED) |->
    out_data.rep_bytes == '0 && out_data.rep_datagrams == '0 &&
    out_data.rep_dropped == '0 && out_data.rep_out_of_order == '0 &&
    out_data.rep_duration_ms == '0)
    else $error("report fields set on plain result");

  // interim report has no out-of-order count
  a_interim_ooo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_INTERIM |-> out_data.rep_out_of_order == '0)
    else $error("out-of-order count on interim report");

endmodule

bind datagram_loss_monitor dlm_checker u_dlm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/datagram_loss_monitor_tb.sv @@
`timescale 1ns / 1ps

module datagram_loss_monitor_tb;
  import dlm_pkg::*;

  localparam int CNT_W = COUNT_WIDTH_DEFAULT;
  localparam logic [47:0] COUNT_MAX = (CNT_W >= 48) ? '1 : ((48'd1 << CNT_W) - 48'd1);
  localparam int LONG_HOLD = 150;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  dlm_in_t in_data;
  logic out_valid;
  logic out_ready;
  dlm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [INTERVAL_WIDTH-1:0] cfg_data;

  datagram_loss_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Tracker mirror: interval register and session/window counters
  logic [INTERVAL_WIDTH-1:0] interval_ms;
  bit          hunting_start;
  logic [7:0]  sess_num;
  logic [31:0] sess_start;
  logic [31:0] next_seq;
  logic [47:0] tot_bytes, tot_dgrams, tot_drop;
  logic [31:0] tot_late;
  bit          win_open;
  logic [31:0] win_start;
  logic [47:0] win_bytes, win_dgrams, win_drop;

  dlm_out_t expected_results[$];

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int in_stall_cycles = 0;
  int interval_writes = 0;
  int kind_seen[4] = '{0, 0, 0, 0};

  // Stimulus controls
  bit src_gaps = 0;
  bit sink_gaps = 0;
  bit long_hold_req = 0;
  int hold_left = 0;
  logic [31:0] clock_ms = 0;
  int unsigned step_max = 50;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Timeout at %0t ns with %0d results outstanding", $time, expected_results.size());
    $display("FAIL datagram_loss_monitor");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] sat_count(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, COUNT_MAX}) return COUNT_MAX;
    return s[47:0];
  endfunction

  task automatic clear_tracker();
    interval_ms = INTERVAL_RESET;
    hunting_start = 1;
    sess_num = '0;
    sess_start = '0;
    next_seq = '0;
    tot_bytes = '0;
    tot_dgrams = '0;
    tot_drop = '0;
    tot_late = '0;
    win_open = 0;
    win_start = '0;
    win_bytes = '0;
    win_dgrams = '0;
    win_drop = '0;
  endtask

  // Advance the mirror by one datagram and return the word it should produce
  function automatic dlm_out_t track_datagram(dlm_in_t d);
    dlm_out_t r;
    logic [31:0] id, now, gap, elapsed;
    r = '0;
    id = d.seq_id;
    now = d.now_ms;
    if (hunting_start) begin
      if (id != 32'd0) begin
        r.result_kind = KIND_IGNORED;
        r.session_number = sess_num;
        return r;
      end
      // id 0 opens a new session
      sess_num = sess_num + 8'd1;
      sess_start = now;
      next_seq = '0;
      tot_bytes = '0;
      tot_dgrams = '0;
      tot_drop = '0;
      tot_late = '0;
      win_open = 0;
      win_start = '0;
      win_bytes = '0;
      win_dgrams = '0;
      win_drop = '0;
      hunting_start = 0;
    end
    r.session_number = sess_num;

    // negative id closes the session
    if (id[31]) begin
      r.result_kind = KIND_FINAL;
      r.rep_bytes = tot_bytes;
      r.rep_datagrams = tot_dgrams;
      r.rep_dropped = tot_drop;
      r.rep_out_of_order = tot_late;
      r.rep_duration_ms = now - sess_start;
      hunting_start = 1;
      return r;
    end

    // sequence tracking, unsigned compare
    if (id == next_seq) begin
      next_seq = next_seq + 32'd1;
    end else if (id > next_seq) begin
      gap = id - next_seq;
      tot_drop = sat_count(tot_drop, {16'd0, gap});
      win_drop = sat_count(win_drop, {16'd0, gap});
      next_seq = id + 32'd1;
    end else if (tot_late != '1) begin
      tot_late = tot_late + 32'd1;
    end
    tot_dgrams = sat_count(tot_dgrams, 48'd1);
    tot_bytes = sat_count(tot_bytes, {32'd0, d.byte_count});
    r.result_kind = KIND_COUNTED;

    // interim window
    if (interval_ms != '0) begin
      win_dgrams = sat_count(win_dgrams, 48'd1);
      win_bytes = sat_count(win_bytes, {32'd0, d.byte_count});
      if (win_open) begin
        elapsed = now - win_start;
        if (elapsed >= {10'd0, interval_ms}) begin
          r.result_kind = KIND_INTERIM;
          r.rep_bytes = win_bytes;
          r.rep_datagrams = win_dgrams;
          r.rep_dropped = win_drop;
          r.rep_duration_ms = elapsed;
          win_open = 0;
          win_start = '0;
          win_bytes = '0;
          win_dgrams = '0;
          win_drop = '0;
        end
      end else begin
        win_open = 1;
        win_start = now;
      end
    end
    return r;
  endfunction

  // Offer one datagram word, hold it until taken, then maybe idle
  task automatic send_datagram(logic [31:0] id, logic [15:0] nbytes, logic [31:0] now);
    dlm_in_t w;
    int g;
    w.seq_id = id;
    w.byte_count = nbytes;
    w.now_ms = now;
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(posedge clk);
      if (!in_ready) in_stall_cycles++;
    end while (!in_ready);
    expected_results.push_back(track_datagram(w));
    words_sent++;
    g = src_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Interval writes only happen with nothing in flight
  task automatic write_interval(logic [INTERVAL_WIDTH-1:0] v);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    interval_ms = v;
    interval_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    errors++;
  endtask

  task automatic check_result(dlm_out_t e, dlm_out_t a);
    if (a.result_kind !== e.result_kind)
      report_field("result_kind", e.result_kind, a.result_kind);
    if (a.session_number !== e.session_number)
      report_field("session_number", e.session_number, a.session_number);
    if (a.rep_bytes !== e.rep_bytes)
      report_field("rep_bytes", e.rep_bytes, a.rep_bytes);
    if (a.rep_datagrams !== e.rep_datagrams)
      report_field("rep_datagrams", e.rep_datagrams, a.rep_datagrams);
    if (a.rep_dropped !== e.rep_dropped)
      report_field("rep_dropped", e.rep_dropped, a.rep_dropped);
    if (a.rep_out_of_order !== e.rep_out_of_order)
      report_field("rep_out_of_order", e.rep_out_of_order, a.rep_out_of_order);
    if (a.rep_duration_ms !== e.rep_duration_ms)
      report_field("rep_duration_ms", e.rep_duration_ms, a.rep_duration_ms);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      kind_seen[out_data.result_kind]++;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result word, kind %0d", $time, out_data.result_kind);
        errors++;
      end else begin
        check_result(expected_results.pop_front(), out_data);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        hold_left = gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand_bytes();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic advance_clock();
    clock_ms = clock_ms + $urandom_range(0, step_max);
  endtask

  // One session with random content; ids mostly in order
  task automatic run_session(int n_items, bit close_it);
    logic [31:0] id;
    int r;
    if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
    send_datagram(32'd0, rand_bytes(), clock_ms);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) id = next_seq;
      else if (r < 82) id = next_seq + $urandom_range(1, 5);
      else if (r < 86) id = $urandom & 32'h7FFF_FFFF;
      else if (r < 96) id = (next_seq == 0) ? 32'd0 : $urandom_range(0, next_seq - 1);
      else id = 32'd0;
      advance_clock();
      send_datagram(id, rand_bytes(), clock_ms);
    end
    if (close_it) begin
      advance_clock();
      send_datagram($urandom | 32'h8000_0000, rand_bytes(), clock_ms);
    end
  endtask

  task automatic send_noise(int n);
    logic [31:0] id;
    repeat (n) begin
      id = $urandom;
      if (id == 32'd0) id = 32'd1;
      send_datagram(id, rand_bytes(), $urandom);
    end
  endtask

  // Before any id 0 everything is dropped, negative ids included
  task automatic test_idle_ignore();
    send_datagram(32'd5, 16'd100, 32'd0);
    send_datagram(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_datagram(32'h7FFF_FFFF, 16'd0, 32'd7);
    send_datagram(32'h8000_0000, 16'd1, 32'd8);
  endtask

  // In order, gap, late and close within one session
  task automatic test_sequence_tracking();
    send_datagram(32'd0, 16'd0, 32'd0);
    send_datagram(32'd1, 16'hFFFF, 32'd1);
    send_datagram(32'd2, 16'd1500, 32'd2);
    send_datagram(32'd10, 16'd64, 32'd3);
    send_datagram(32'd5, 16'd64, 32'd4);
    send_datagram(32'd11, 16'd64, 32'd5);
    send_datagram(32'h7FFF_FFFF, 16'd9000, 32'd6);
    send_datagram(32'd3, 16'd1, 32'd7);
    send_datagram(32'hFFFF_FFFF, 16'd2, 32'd900);
  endtask

  // Window report on exact interval, across the ms counter wrap
  task automatic test_window_wrap();
    write_interval(22'd5);
    send_datagram(32'd0, 16'd10, 32'hFFFF_FFFE);
    send_datagram(32'd1, 16'd20, 32'hFFFF_FFFF);
    send_datagram(32'd2, 16'd30, 32'd3);
    send_datagram(32'd3, 16'd40, 32'd4);
    send_datagram(32'h8000_0000, 16'd0, 32'd4);
  endtask

  // Zero interval: window drops still accumulate and carry into the next window
  task automatic test_zero_interval();
    write_interval(22'd0);
    send_datagram(32'd0, 16'd100, 32'd100);
    send_datagram(32'd1, 16'd100, 32'd101);
    send_datagram(32'd5, 16'd100, 32'd102);
    write_interval(22'd3);
    send_datagram(32'd6, 16'd100, 32'd200);
    send_datagram(32'd7, 16'd100, 32'd203);
    send_datagram(32'h9000_0000, 16'd0, 32'd210);
  endtask

  // Receiver holds off while the sender keeps pushing words
  task automatic test_backpressure();
    bit saved;
    wait_for_results();
    saved = src_gaps;
    src_gaps = 0;
    long_hold_req = 1;
    send_datagram(32'd0, rand_bytes(), clock_ms);
    repeat (24) begin
      advance_clock();
      send_datagram(next_seq, rand_bytes(), clock_ms);
    end
    send_datagram(32'h8000_0001, rand_bytes(), clock_ms);
    src_gaps = saved;
    wait_for_results();
  endtask

  // Many short sessions so the session number wraps
  task automatic test_session_rollover();
    write_interval(22'd2);
    step_max = 3;
    src_gaps = 1;
    sink_gaps = 1;
    repeat (260) begin
      run_session($urandom_range(0, 1), 1'b1);
      if ($urandom_range(0, 7) == 0) send_noise(1);
    end
  endtask

  // Random sessions under a series of interval settings, extremes included
  task automatic test_random_traffic();
    logic [INTERVAL_WIDTH-1:0] settings[6];
    int phase_start;
    settings = '{22'd0, 22'd1, 22'd1000, 22'd3600000, 22'h3FFFFF, 22'd0};
    settings[5] = INTERVAL_WIDTH'($urandom_range(2, 3600000));
    foreach (settings[i]) begin
      write_interval(settings[i]);
      step_max = (settings[i] == 0) ? 50 : settings[i] / 2 + 2;
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      phase_start = words_sent;
      while (words_sent - phase_start < 80) begin
        run_session($urandom_range(1, 25), $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 3));
      end
    end
    // stretch with no idling on either side
    wait_for_results();
    src_gaps = 0;
    sink_gaps = 0;
    run_session(30, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    clear_tracker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_idle_ignore();
    test_sequence_tracking();
    test_window_wrap();
    test_zero_interval();
    test_backpressure();
    test_session_rollover();
    test_random_traffic();
    test_backpressure();

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d datagram words over %0d interval settings, %0d input stall cycles",
             words_sent, interval_writes, in_stall_cycles);
    $display("Checked %0d results: %0d ignored, %0d counted, %0d interim, %0d final",
             results_seen, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (errors == 0) begin
      $display("PASS datagram_loss_monitor");
    end else begin
      $display("FAIL datagram_loss_monitor");
    end
    $finish;
  end

endmodule
